// ----- rtl/pevc_pkg.sv -----
// Shared types, constants and reciprocal multipliers for the volume control block.
// No dependencies.
package pevc_pkg;

    localparam int VOL_W    = 14;
    localparam int MV_W     = 12;
    localparam int ROT_W    = 16;
    localparam int DB_W     = 8;
    localparam int DPR_W    = 9;
    localparam int CODE_W   = 8;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 27;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DELTA_W  = 24;
    localparam int DET_W    = 16;

    localparam logic [VOL_W-1:0]  VOL_FULL     = 14'd13668;
    localparam logic [MV_W-1:0]   MUTE_ON_MV   = 12'd100;
    localparam logic [MV_W-1:0]   MUTE_OFF_MV  = 12'd120;
    localparam logic [MV_W-1:0]   POT_TOP_MV   = 12'd3300;
    localparam logic [CODE_W-1:0] NO_CODE      = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_TOP     = 8'd40;
    localparam logic [DPR_W-1:0]  DPR_RESET    = 9'd24;
    localparam logic [MUL_B_W-1:0] VOL_STEP    = 27'd911;
    localparam logic [MUL_B_W-1:0] GAIN_SLOPE  = 27'd41;
    localparam logic [15:0]       Q15_MAX      = 16'h7FFF;
    localparam logic [MUL_A_W-1:0] POT_ROUND   = 26'd1590;
    localparam logic [MUL_A_W-1:0] ENC_ROUND   = 26'd180;

    // Round-up reciprocals, exact for any dividend below 2**MUL_A_W.
    localparam int SH_POT = 38;
    localparam int SH_ENC = 35;
    localparam int SH_3   = 28;
    localparam logic [63:0] RECIP_POT_FULL = ((64'd1 << SH_POT) + 64'd3179) / 64'd3180;
    localparam logic [63:0] RECIP_ENC_FULL = ((64'd1 << SH_ENC) + 64'd359) / 64'd360;
    localparam logic [63:0] RECIP_3_FULL   = ((64'd1 << SH_3) + 64'd2) / 64'd3;
    localparam logic [MUL_B_W-1:0] RECIP_POT = RECIP_POT_FULL[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] RECIP_ENC = RECIP_ENC_FULL[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] RECIP_3   = RECIP_3_FULL[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] POT_SCALE = 27'd13668;

    typedef enum logic [1:0] {
        REQ_POT  = 2'd0,
        REQ_ENC  = 2'd1,
        REQ_DB   = 2'd2,
        REQ_NONE = 2'd3
    } t_req_kind;

    typedef logic [1:0] t_step;

    typedef struct packed {
        logic  load;
        logic  mul;
        t_step step;
        logic  commit;
    } t_dp_cmd;

    typedef struct packed {
        t_req_kind kind;
        logic      out_free;
    } t_dp_status;

    typedef struct packed {
        logic             volume_update;
        logic [VOL_W-1:0] volume_level;
        logic             mute_update;
        logic             mute_value;
        logic             amp_enable_update;
        logic             amp_enable;
    } t_vol_rsp;

    // Index of the last multiplier step for each request kind.
    function automatic t_step last_step(input t_req_kind kind);
        t_step s;
        case (kind)
            REQ_POT: s = 2'd2;
            REQ_ENC: s = 2'd3;
            REQ_DB:  s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/pevc_if.sv -----
// Request and response channel interfaces (valid/ready) for the volume control block.
// Depends on pevc_pkg.
interface pevc_req_if import pevc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [MV_W-1:0]         pot_millivolts;
    logic signed [ROT_W-1:0] rotation_degrees;
    logic signed [DB_W-1:0]  step_decibels;

    modport source (output valid, output req_type, output pot_millivolts,
                    output rotation_degrees, output step_decibels, input ready);
    modport sink   (input valid, input req_type, input pot_millivolts,
                    input rotation_degrees, input step_decibels, output ready);
endinterface

interface pevc_rsp_if import pevc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             volume_update;
    logic [VOL_W-1:0] volume_level;
    logic             mute_update;
    logic             mute_value;
    logic             amp_enable_update;
    logic             amp_enable;

    modport source (output valid, output volume_update, output volume_level,
                    output mute_update, output mute_value, output amp_enable_update,
                    output amp_enable, input ready);
    modport sink   (input valid, input volume_update, input volume_level,
                    input mute_update, input mute_value, input amp_enable_update,
                    input amp_enable, output ready);
endinterface

// ----- rtl/pot_encoder_volume_control_top.sv -----
// Items are handled one at a time: a new item is taken only once the previous one has
//   committed, and the single shared multiplier walks each item through one step per cycle.
// The output register decouples the sides: a new item is taken while a result waits.
// Reset (i_rst_n low, synchronous): volume 13668, muted, no gain code, 24 detents/rev,
//   output empty.
module pot_encoder_volume_control_top import pevc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,    // detents per revolution write
    input  logic [DPR_W-1:0]  i_cfg_wr_data,
    pevc_req_if.sink          i_req,
    pevc_rsp_if.source        o_rsp
);

    t_dp_cmd    w_cmd;      // sequencer -> datapath
    t_dp_status w_status;   // datapath -> sequencer
    t_vol_rsp   w_rsp;
    logic       w_req_ready;
    logic       w_rsp_valid;

    // Sequencer: idle -> one multiplier step per cycle -> commit.
    pevc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: holds volume, mute flag, last gain code and the output item.
    pevc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_req_type         (i_req.req_type),
        .i_pot_millivolts   (i_req.pot_millivolts),
        .i_rotation_degrees (i_req.rotation_degrees),
        .i_step_decibels    (i_req.step_decibels),
        .i_rsp_ready        (o_rsp.ready),
        .o_rsp_valid        (w_rsp_valid),
        .o_rsp              (w_rsp)
    );

    assign i_req.ready             = w_req_ready;
    assign o_rsp.valid             = w_rsp_valid;
    assign o_rsp.volume_update     = w_rsp.volume_update;
    assign o_rsp.volume_level      = w_rsp.volume_level;
    assign o_rsp.mute_update       = w_rsp.mute_update;
    assign o_rsp.mute_value        = w_rsp.mute_value;
    assign o_rsp.amp_enable_update = w_rsp.amp_enable_update;
    assign o_rsp.amp_enable        = w_rsp.amp_enable;

endmodule

// ----- rtl/pevc_ctrl.sv -----
// Sequencer: accepts an item, steps the shared multiplier, then commits the result.
// Depends on pevc_pkg.
module pevc_ctrl import pevc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MUL    = 3'b010,
        S_COMMIT = 3'b100
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    t_step       r_step, n_step;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.step = r_step;
                if (r_step == last_step(i_status.kind)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_COMMIT: begin
                // hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ----- rtl/pevc_dp.sv -----
// Datapath: item capture, shared multiplier, volume/mute/gain-code state, output register.
// Depends on pevc_pkg.
module pevc_dp import pevc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_wr_en,
    input  logic [DPR_W-1:0]        i_cfg_wr_data,
    input  logic [1:0]              i_req_type,
    input  logic [MV_W-1:0]         i_pot_millivolts,
    input  logic signed [ROT_W-1:0] i_rotation_degrees,
    input  logic signed [DB_W-1:0]  i_step_decibels,
    input  logic                    i_rsp_ready,
    output logic                    o_rsp_valid,
    output t_vol_rsp                o_rsp
);

    logic [DPR_W-1:0]  r_dpr;
    t_req_kind         r_kind;
    logic [MV_W-1:0]   r_mv;
    logic [ROT_W-1:0]  r_rot;
    logic [DB_W-1:0]   r_db;
    logic [PROD_W-1:0] r_prod;
    logic [VOL_W-1:0]  r_lvl;
    logic [VOL_W-1:0]  r_volume, n_volume;
    logic              r_mute, n_mute;
    logic [CODE_W-1:0] r_last_code, n_last_code;
    logic              r_out_valid;
    t_vol_rsp          r_out, n_out;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ROT_W-1:0]   rot_mag;
    logic [DB_W-1:0]    db_mag;
    logic [MV_W-1:0]    mv_clamp;
    logic [MV_W-1:0]    rel;
    logic [DET_W-1:0]   det;
    logic [DET_W-1:0]   det_fix;

    // gain code and volume move
    logic [19:0]        gx;
    logic [4:0]         gq0;
    logic [15:0]        glow;
    logic [4:0]         gq;
    logic [CODE_W-1:0]  code;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W:0]   sum_up;
    logic [VOL_W-1:0]   vol_up;
    logic [VOL_W-1:0]   vol_dn;
    logic               move_up;

    always_comb begin
        rot_mag  = r_rot[ROT_W-1] ? (~r_rot + 16'd1) : r_rot;
        db_mag   = r_db[DB_W-1] ? (~r_db + 8'd1) : r_db;
        mv_clamp = (r_mv > POT_TOP_MV) ? POT_TOP_MV : r_mv;
        rel      = (mv_clamp > MUTE_OFF_MV) ? (mv_clamp - MUTE_OFF_MV) : '0;
        det      = r_prod[SH_ENC +: DET_W];
        det_fix  = (det == '0) ? 16'd1 : det;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_kind)
            REQ_POT: begin
                case (i_cmd.step)
                    2'd0: begin
                        mul_a = MUL_A_W'(rel);
                        mul_b = POT_SCALE;
                    end
                    2'd1: begin
                        mul_a = r_prod[MUL_A_W-1:0] + POT_ROUND;
                        mul_b = RECIP_POT;
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_prod[SH_POT +: VOL_W]);
                        mul_b = GAIN_SLOPE;
                    end
                endcase
            end
            REQ_ENC: begin
                case (i_cmd.step)
                    2'd0: begin
                        mul_a = MUL_A_W'(rot_mag);
                        mul_b = MUL_B_W'(r_dpr);
                    end
                    2'd1: begin
                        mul_a = r_prod[MUL_A_W-1:0] + ENC_ROUND;
                        mul_b = RECIP_ENC;
                    end
                    2'd2: begin
                        mul_a = MUL_A_W'(det_fix);
                        mul_b = VOL_STEP;
                    end
                    default: begin
                        mul_a = r_prod[MUL_A_W-1:0];
                        mul_b = RECIP_3;
                    end
                endcase
            end
            REQ_DB: begin
                case (i_cmd.step)
                    2'd0: begin
                        mul_a = MUL_A_W'(db_mag);
                        mul_b = VOL_STEP;
                    end
                    default: begin
                        mul_a = r_prod[MUL_A_W-1:0];
                        mul_b = RECIP_3;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // commit: gain code, volume move, state update
    always_comb begin
        // lvl*41 / 32767 via x>>15 plus one correction
        gx     = r_prod[19:0];
        gq0    = gx[19:15];
        glow   = {1'b0, gx[14:0]} + {11'd0, gq0};
        gq     = gq0 + ((glow >= Q15_MAX) ? 5'd1 : 5'd0);
        code   = CODE_TOP - {3'd0, gq};

        delta  = r_prod[SH_3 +: DELTA_W];
        sum_up = {11'd0, r_volume} + {1'b0, delta};
        vol_up = (sum_up > {11'd0, VOL_FULL}) ? VOL_FULL : sum_up[VOL_W-1:0];
        vol_dn = (delta >= {10'd0, r_volume}) ? '0 : (r_volume - delta[VOL_W-1:0]);
        move_up = (r_kind == REQ_ENC) ? r_rot[ROT_W-1] : !r_db[DB_W-1];

        n_volume    = r_volume;
        n_mute      = r_mute;
        n_last_code = r_last_code;
        n_out       = '0;

        case (r_kind)
            REQ_POT: begin
                n_out.amp_enable_update = 1'b1;
                n_out.amp_enable        = (r_mv != '0);
                if (r_mv <= MUTE_ON_MV) begin
                    if (!r_mute) begin
                        n_mute            = 1'b1;
                        n_out.mute_update = 1'b1;
                        n_last_code       = NO_CODE;
                    end
                end else begin
                    if (r_mute && (r_mv >= MUTE_OFF_MV)) begin
                        n_mute            = 1'b0;
                        n_out.mute_update = 1'b1;
                    end
                    if (code != r_last_code) begin
                        n_volume            = r_lvl;
                        n_out.volume_update = 1'b1;
                        n_last_code         = code;
                    end
                end
            end
            REQ_ENC: begin
                if (r_rot != '0) begin
                    n_volume            = move_up ? vol_up : vol_dn;
                    n_out.volume_update = 1'b1;
                end
            end
            REQ_DB: begin
                n_volume            = move_up ? vol_up : vol_dn;
                n_out.volume_update = 1'b1;
            end
            default: begin
                n_volume = r_volume;
            end
        endcase

        n_out.volume_level = n_volume;
        n_out.mute_value   = n_mute;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpr       <= DPR_RESET;
            r_volume    <= VOL_FULL;
            r_mute      <= 1'b1;
            r_last_code <= NO_CODE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dpr <= i_cfg_wr_data;
            end
            if (i_cmd.commit) begin
                r_volume    <= n_volume;
                r_mute      <= n_mute;
                r_last_code <= n_last_code;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_req_kind'(i_req_type);
            r_mv   <= i_pot_millivolts;
            r_rot  <= i_rotation_degrees;
            r_db   <= i_step_decibels;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_b;
            if ((r_kind == REQ_POT) && (i_cmd.step == 2'd2)) begin
                r_lvl <= r_prod[SH_POT +: VOL_W];
            end
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp             = r_out;

endmodule

// ----- rtl/pevc_checker.sv -----
// Port-level checks for the volume control top, attached by bind.
// Depends on pevc_pkg and pot_encoder_volume_control_top.
module pevc_checker import pevc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [VOL_W-1:0] i_volume_level,
    input logic             i_mute_update,
    input logic             i_amp_enable_update,
    input logic             i_amp_enable
);

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_volume_level <= VOL_FULL))
        else $error("volume level above full scale");

    a_mute_on_pot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_mute_update) |-> i_amp_enable_update)
        else $error("mute change on a non-pot item");

    a_amp_on_pot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_amp_enable_update) |-> !i_amp_enable)
        else $error("amp enable set on a non-pot item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous item in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_volume_level)))
        else $error("stalled result dropped or changed");

endmodule

bind pot_encoder_volume_control_top pevc_checker u_pevc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_volume_level      (o_rsp.volume_level),
    .i_mute_update       (o_rsp.mute_update),
    .i_amp_enable_update (o_rsp.amp_enable_update),
    .i_amp_enable        (o_rsp.amp_enable)
);
